// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a clock and an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/rgbes_pkg.sv =====
// ---------------------------------------------------------------------------
// RGB effect sequencer package
// Types, register codes and color tables shared by the sequencer modules.
// ---------------------------------------------------------------------------
package rgbes_pkg;

    localparam logic [1:0] MODE_JUMP    = 2'd0;
    localparam logic [1:0] MODE_GRADUAL = 2'd1;
    localparam logic [1:0] MODE_PULSE   = 2'd2;

    localparam logic [1:0] REG_EFFECT_MODE = 2'd0;
    localparam logic [1:0] REG_SPEED_LEVEL = 2'd1;
    localparam logic [1:0] REG_SPEED       = 2'd2;

    localparam logic [7:0] SPEED_LEVEL_RESET = 8'd99;
    localparam logic [7:0] LEVEL_FULL        = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t       color;
        logic [2:0] step;
    } result_t;

    function automatic rgb_t jump_colour(input logic [2:0] idx);
        rgb_t c;
        case (idx)
            3'd0:    c = '{8'd255, 8'd0,   8'd0};
            3'd1:    c = '{8'd0,   8'd255, 8'd0};
            3'd2:    c = '{8'd0,   8'd0,   8'd255};
            3'd3:    c = '{8'd200, 8'd235, 8'd20};
            3'd4:    c = '{8'd255, 8'd255, 8'd0};
            3'd5:    c = '{8'd255, 8'd0,   8'd255};
            3'd6:    c = '{8'd0,   8'd255, 8'd255};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    function automatic rgb_t pulse_target(input logic [1:0] idx);
        rgb_t c;
        case (idx)
            2'd1:    c = '{8'd0,   8'd255, 8'd0};
            2'd2:    c = '{8'd0,   8'd0,   8'd255};
            default: c = '{8'd255, 8'd0,   8'd0};
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/rgb_effect_sequencer.sv =====
// ---------------------------------------------------------------------------
// RGB effect sequencer
// Tick-driven RGB lighting effects: color jump, gradual hue ramp and pulse
// fade, with one color result for every input item.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid, in_stall   tick
//  out      output     out_valid, out_stall red/green/blue_level, effect_step
//  cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// One item is accepted per cycle unless in_stall is high; its result is registered.
// The effect state updates in the accepting cycle, together with the buffered result.
// A skid entry behind the result register absorbs one item while out is stalled.
// Reset is asynchronous: default config, cleared effect state, no buffered results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_effect_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       tick,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_level,
    output logic [7:0] green_level,
    output logic [7:0] blue_level,
    output logic [2:0] effect_step
);
    import rgbes_pkg::*;

    logic    accept;
    result_t core_result;
    result_t out_result;

    assign accept = in_valid && !in_stall;

    rgbes_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .tick      (tick),
        .result    (core_result)
    );

    rgbes_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_data   (core_result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign red_level   = out_result.color.red;
    assign green_level = out_result.color.green;
    assign blue_level  = out_result.color.blue;
    assign effect_step = out_result.step;

    `CHK_SAME(a_stall_has_result, clk, rst_n, in_stall, out_valid)
    `CHK_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid)
    `CHK_NEXT(a_skid_drains, clk, rst_n, in_stall && !out_stall, !in_stall)

endmodule

// ===== hw/rtl/rgbes_core.sv =====
// ---------------------------------------------------------------------------
// RGB effect sequencer core
// Holds the configuration and effect state and computes the next color
// and step for each accepted item combinationally.
// ---------------------------------------------------------------------------
module rgbes_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              accept,
    input  logic              tick,
    output rgbes_pkg::result_t result
);
    import rgbes_pkg::*;

    logic [1:0] mode_reg;
    logic [7:0] level_reg;
    logic [7:0] speed_reg;
    rgb_t       rgb_reg,   rgb_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic       half_reg,  half_next;

    logic [7:0] period;
    logic [7:0] count_inc;
    logic       fires;
    rgb_t       target;
    rgb_t       pulsed;

    assign period    = (level_reg > speed_reg) ? 8'(level_reg - speed_reg) : 8'd0;
    assign count_inc = 8'(count_reg + 8'd1);
    assign fires     = (count_inc >= period);
    assign target    = pulse_target((phase_reg < 3'd3) ? phase_reg[1:0] : 2'd0);

    always_comb
    begin
        pulsed.red   = (rgb_reg.red   > target.red)   ? 8'(rgb_reg.red   - 8'd1) : target.red;
        pulsed.green = (rgb_reg.green > target.green) ? 8'(rgb_reg.green - 8'd1) : target.green;
        pulsed.blue  = (rgb_reg.blue  > target.blue)  ? 8'(rgb_reg.blue  - 8'd1) : target.blue;
    end

    always_comb
    begin
        rgb_next   = rgb_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        half_next  = half_reg;
        if (accept && tick)
        begin
            case (mode_reg)
                MODE_JUMP:
                begin
                    rgb_next = jump_colour(phase_reg);
                    if (half_reg)
                    begin
                        half_next  = 1'b0;
                        count_next = fires ? 8'd0 : count_inc;
                        if (fires)
                        begin
                            phase_next = 3'(phase_reg + 3'd1);
                        end
                    end
                    else
                    begin
                        half_next = 1'b1;
                    end
                end
                MODE_GRADUAL:
                begin
                    count_next = fires ? 8'd0 : count_inc;
                    if (fires)
                    begin
                        case (phase_reg)
                            3'd0:
                            begin
                                rgb_next = '{LEVEL_FULL, 8'(rgb_reg.green + 8'd1), 8'd0};
                                if (rgb_next.green == LEVEL_FULL) phase_next = 3'd1;
                            end
                            3'd1:
                            begin
                                rgb_next = '{8'(rgb_reg.red - 8'd1), LEVEL_FULL, 8'd0};
                                if (rgb_next.red == 8'd0) phase_next = 3'd2;
                            end
                            3'd2:
                            begin
                                rgb_next = '{8'd0, LEVEL_FULL, 8'(rgb_reg.blue + 8'd1)};
                                if (rgb_next.blue == LEVEL_FULL) phase_next = 3'd3;
                            end
                            3'd3:
                            begin
                                rgb_next = '{8'd0, 8'(rgb_reg.green - 8'd1), LEVEL_FULL};
                                if (rgb_next.green == 8'd0) phase_next = 3'd4;
                            end
                            3'd4:
                            begin
                                rgb_next = '{8'(rgb_reg.red + 8'd1), 8'd0, LEVEL_FULL};
                                if (rgb_next.red == LEVEL_FULL) phase_next = 3'd5;
                            end
                            3'd5:
                            begin
                                rgb_next = '{LEVEL_FULL, 8'd0, 8'(rgb_reg.blue - 8'd1)};
                                if (rgb_next.blue == 8'd0) phase_next = 3'd0;
                            end
                            default:
                            begin
                                rgb_next = rgb_reg;
                            end
                        endcase
                    end
                end
                MODE_PULSE:
                begin
                    count_next = fires ? 8'd0 : count_inc;
                    if (fires)
                    begin
                        rgb_next = pulsed;
                        if (pulsed == target)
                        begin
                            phase_next = (phase_reg < 3'd2) ? 3'(phase_reg + 3'd1) : 3'd0;
                        end
                    end
                end
                default:
                begin
                    rgb_next = rgb_reg;
                end
            endcase
        end
        if (cfg_wr_en && (cfg_index == REG_EFFECT_MODE))
        begin
            case (cfg_data[1:0])
                MODE_JUMP:
                begin
                    rgb_next   = '{8'd0, 8'd0, 8'd0};
                    phase_next = 3'd0;
                    count_next = 8'd0;
                    half_next  = 1'b0;
                end
                MODE_GRADUAL:
                begin
                    rgb_next   = '{8'd0, 8'd0, 8'd0};
                    phase_next = 3'd0;
                    count_next = 8'd0;
                end
                MODE_PULSE:
                begin
                    rgb_next   = '{LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
                    phase_next = 3'd0;
                    half_next  = 1'b0;
                end
                default:
                begin
                    rgb_next = rgb_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_JUMP;
            level_reg <= SPEED_LEVEL_RESET;
            speed_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE: mode_reg  <= cfg_data[1:0];
                REG_SPEED_LEVEL: level_reg <= cfg_data;
                REG_SPEED:       speed_reg <= cfg_data;
                default:         mode_reg  <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_reg   <= '{8'd0, 8'd0, 8'd0};
            phase_reg <= 3'd0;
            count_reg <= 8'd0;
            half_reg  <= 1'b0;
        end
        else
        begin
            rgb_reg   <= rgb_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            half_reg  <= half_next;
        end
    end

    assign result.color = rgb_next;
    assign result.step  = phase_next;

endmodule

// ===== hw/rtl/rgbes_out_buf.sv =====
// ---------------------------------------------------------------------------
// RGB effect sequencer output buffer
// Two-entry result register with a skid stage so that a new item can be
// taken while a finished result is still stalled.
// ---------------------------------------------------------------------------
module rgbes_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  rgbes_pkg::result_t wr_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output rgbes_pkg::result_t out_data
);
    import rgbes_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;
    logic    pop;

    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (wr_en)
        begin
            if (pop || !main_valid_reg)
            begin
                main_next       = wr_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = wr_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
